FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the amount codec RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ACC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition at one edge demands an expression at the next edge.
`define ACC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

FILE: src/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Types, constants and per-stage operations of the amount codec pipeline.
// ----------------------------------------------------------------------------
package acc_pkg;

   localparam int ACC_WIDTH       = 64;
   localparam int ACC_ROUNDS      = 10;  // nine strip rounds and one digit split
   localparam int ACC_PHASES      = 3;   // stages of one divide by a constant
   localparam int ACC_POST_STEPS  = 4;
   localparam int ACC_SCALE_STEPS = 9;
   localparam int ACC_NUM_STAGES  = 1 + ACC_PHASES * ACC_ROUNDS + ACC_POST_STEPS
                                    + ACC_SCALE_STEPS;

   localparam logic [3:0] ACC_LAST_ROUND = 4'(ACC_ROUNDS - 1);
   localparam logic [3:0] ACC_MAX_STRIP  = 4'd9;
   localparam logic [3:0] ACC_DIV_TEN    = 4'd10;
   localparam logic [3:0] ACC_DIV_NINE   = 4'd9;

   typedef enum logic [3:0] {
      OP_PREP,
      OP_EST_A,
      OP_EST_B,
      OP_FIX,
      OP_MUL_A,
      OP_ADD_D,
      OP_MUL_B,
      OP_ADD_E,
      OP_SCALE
   } acc_op_type;

   typedef struct packed {
      logic                 mode;
      logic                 zero;
      logic                 fin;
      logic [3:0]           e;
      logic [3:0]           d;
      logic [3:0]           r;
      logic [ACC_WIDTH-1:0] n;
      logic [ACC_WIDTH-1:0] t;
   } acc_item_type;

   // Operation performed by pipeline stage k.
   function automatic acc_op_type acc_stage_op(int k);
      int         j;
      acc_op_type op;
      j  = 0;
      op = OP_SCALE;
      if (k == 0) begin
         op = OP_PREP;
      end else if (k <= ACC_PHASES * ACC_ROUNDS) begin
         j = (k - 1) % ACC_PHASES;
         op = (j == 0) ? OP_EST_A : ((j == 1) ? OP_EST_B : OP_FIX);
      end else begin
         j = k - 1 - ACC_PHASES * ACC_ROUNDS;
         priority case (j)
            0:       op = OP_MUL_A;
            1:       op = OP_ADD_D;
            2:       op = OP_MUL_B;
            3:       op = OP_ADD_E;
            default: op = OP_SCALE;
         endcase
      end
      return op;
   endfunction

   // Divide round that stage k belongs to.
   function automatic logic [3:0] acc_stage_round(int k);
      logic [3:0] rnd;
      rnd = 4'd0;
      if (k >= 1 && k <= ACC_PHASES * ACC_ROUNDS) begin
         rnd = 4'((k - 1) / ACC_PHASES);
      end
      return rnd;
   endfunction

   // One stage of work. A divide by ten (or nine in the last decode round)
   // runs as a shift-add reciprocal estimate over two stages, then a
   // multiply-back that corrects the quotient by at most one either way.
   function automatic acc_item_type acc_apply(acc_op_type op, logic [3:0] rnd,
                                              acc_item_type s);
      acc_item_type         o;
      logic                 nine;
      logic [3:0]           div4;
      logic [3:0]           rem;
      logic [ACC_WIDTH-1:0] t0;
      logic [ACC_WIDTH-1:0] t1;
      logic [ACC_WIDTH-1:0] t2;
      logic [ACC_WIDTH-1:0] t3;
      logic [ACC_WIDTH-1:0] t4;
      logic [ACC_WIDTH-1:0] qm;
      logic [ACC_WIDTH-1:0] diff;
      logic [ACC_WIDTH-1:0] q;
      o    = s;
      nine = s.mode && (rnd == ACC_LAST_ROUND);
      div4 = nine ? ACC_DIV_NINE : ACC_DIV_TEN;
      rem  = 4'd0;
      t0   = '0;
      t1   = '0;
      t2   = '0;
      t3   = '0;
      t4   = '0;
      qm   = '0;
      diff = '0;
      q    = '0;
      unique case (op)
         OP_PREP: begin
            o.zero = (s.n == '0);
            o.fin  = 1'b0;
            o.e    = 4'd0;
            o.d    = 4'd0;
            o.r    = 4'd0;
            o.t    = '0;
            if (s.mode) begin
               o.n = s.n - 64'd1;
            end
         end
         OP_EST_A: begin
            if (nine) begin
               t0 = s.n - (s.n >> 3);
               t1 = t0 + (t0 >> 6);
            end else begin
               t0 = (s.n >> 1) + (s.n >> 2);
               t1 = t0 + (t0 >> 4);
            end
            o.t = t1;
         end
         OP_EST_B: begin
            if (nine) begin
               t2 = s.t + (s.t >> 12);
               t3 = t2 + (t2 >> 24);
               t4 = t3 + (t3 >> 48);
            end else begin
               t2 = s.t + (s.t >> 8);
               t3 = t2 + (t2 >> 16);
               t4 = t3 + (t3 >> 32);
            end
            o.t = t4 >> 3;
         end
         OP_FIX: begin
            qm   = nine ? ((s.t << 3) + s.t) : ((s.t << 3) + (s.t << 1));
            diff = s.n - qm;
            if (diff[ACC_WIDTH-1]) begin
               q   = s.t - 64'd1;
               rem = 4'(diff[3:0] + div4);
            end else if (diff[4:0] >= {1'b0, div4}) begin
               q   = s.t + 64'd1;
               rem = 4'(diff[3:0] - div4);
            end else begin
               q   = s.t;
               rem = diff[3:0];
            end
            o.r = rem;
            o.t = q;
            if (rnd == ACC_LAST_ROUND) begin
               if (s.e != ACC_MAX_STRIP) begin
                  o.d = s.mode ? 4'(rem + 4'd1) : rem;
                  o.n = q;
               end
            end else if (s.mode) begin
               // The first round of a decode splits off the exponent.
               if (rnd == 4'd0) begin
                  o.e = rem;
                  o.n = q;
               end
            end else if (!s.fin && rem == 4'd0) begin
               o.n = q;
               o.e = 4'(s.e + 4'd1);
            end else begin
               o.fin = 1'b1;
            end
         end
         OP_MUL_A: begin
            if (s.e == ACC_MAX_STRIP) begin
               o.n = s.mode ? (s.n + 64'd1) : ((s.n << 3) + (s.n << 1));
            end else begin
               o.n = s.mode ? ((s.n << 3) + (s.n << 1)) : ((s.n << 3) + s.n);
            end
         end
         OP_ADD_D: begin
            if (s.e != ACC_MAX_STRIP) begin
               o.n = s.n + 64'(s.d) - 64'(!s.mode);
            end
         end
         OP_MUL_B: begin
            if (!s.mode && s.e != ACC_MAX_STRIP) begin
               o.n = (s.n << 3) + (s.n << 1);
            end
         end
         OP_ADD_E: begin
            if (!s.mode && s.e != ACC_MAX_STRIP) begin
               o.n = s.n + 64'(s.e) + 64'd1;
            end
         end
         OP_SCALE: begin
            if (s.mode && s.e != 4'd0) begin
               o.n = (s.n << 3) + (s.n << 1);
               o.e = 4'(s.e - 4'd1);
            end
         end
         default: begin
            o = s;
         end
      endcase
      return o;
   endfunction

endpackage

FILE: src/acc_stage.sv
// ----------------------------------------------------------------------------
// acc_stage
// One register stage of the codec pipeline with its valid bit.
// ----------------------------------------------------------------------------
module acc_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  acc_pkg::acc_op_type  op,
   input  logic [3:0]           rnd,
   input  logic                 in_valid,
   input  acc_pkg::acc_item_type in_item,
   output logic                 out_valid,
   output acc_pkg::acc_item_type out_item
);
   import acc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   acc_item_type item_ff;
   acc_item_type item_in;

   always_comb begin
      valid_in = advance ? in_valid : valid_ff;
      item_in  = advance ? acc_apply(op, rnd, in_item) : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: src/amount_compress_codec.sv
// ----------------------------------------------------------------------------
// amount_compress_codec
// Compact coding of monetary amounts, compress and decompress, pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A request carries req_mode (0 compresses an amount, 1 decompresses a code)
// and the 64-bit req_value. Each request gives exactly one rsp_result, in
// request order, and all arithmetic wraps modulo 2^64. Both channels use a
// valid/ready handshake.
// The block is a 44-stage pipeline: one prepare stage, ten divide rounds of
// three stages each (nine trailing-zero strips and one digit split), four
// multiply/add stages and nine times-ten scaling stages. The last stage
// register drives the response port.
// A request passes from the prepare stage through every stage register in order
// to rsp_valid. While the pipeline advances, one request is taken per cycle, so
// throughput is one result per clock; most of the depth is the ten divides.
// When a result waits and rsp_ready is low, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits; the item registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amount_compress_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result
);
   import acc_pkg::*;

   localparam int NS = ACC_NUM_STAGES;

   logic         advance;
   logic [NS-1:0] vld;
   acc_item_type item [NS];
   acc_item_type req_item;
   acc_item_type last_item;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      req_item      = '0;
      req_item.mode = req_mode;
      req_item.n    = req_value;
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam acc_op_type OP  = acc_stage_op(k);
      localparam logic [3:0] RND = acc_stage_round(k);

      logic         stage_valid;
      acc_item_type stage_item;

      if (k == 0) begin : g_first
         assign stage_valid = req_valid;
         assign stage_item  = req_item;
      end else begin : g_next
         assign stage_valid = vld[k-1];
         assign stage_item  = item[k-1];
      end

      acc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .op        (OP),
         .rnd       (RND),
         .in_valid  (stage_valid),
         .in_item   (stage_item),
         .out_valid (vld[k]),
         .out_item  (item[k])
      );
   end

   assign last_item  = item[NS-1];
   assign rsp_valid  = vld[NS-1];
   assign rsp_result = last_item.zero ? '0 : last_item.n;

   `ACC_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(vld), "pipeline moved during a stall")
   `ACC_ASSERT(a_scale_done, clock, reset, rsp_valid && last_item.mode |-> last_item.e == 4'd0, "decode left exponent unscaled")
   `ACC_ASSERT(a_strip_bound, clock, reset, rsp_valid && !last_item.mode |-> last_item.e <= ACC_MAX_STRIP, "too many zeros stripped")
   `ACC_ASSERT(a_digit_nonzero, clock, reset, rsp_valid && !last_item.mode && !last_item.zero && last_item.e != ACC_MAX_STRIP |-> last_item.d != 4'd0, "split digit is zero")

endmodule
